/* sv/fdsg_pkg.sv */
// ============================================================================
// fdsg_pkg - shared types and constants for the stencil/ghost-fill core
// Field store sizing, word widths, codes, FSM state and the control and
// status bundles that run between the controller and the datapath.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package fdsg_pkg;

    // Field store sizing
    localparam int MAX_POINTS = 1024;
    localparam int MIN_POINTS = 5;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    // point counts hold MAX_POINTS itself and the 11-bit active_points word
    localparam int N_W        = (ADDR_W + 1 > 11) ? ADDR_W + 1 : 11;

    // Word widths
    localparam int SAMPLE_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int SUM_W      = 40;   // signed stencil sums, |s| <= 2^37
    localparam int MAG_W      = 39;   // stencil sum magnitude
    localparam int PROD_W     = MAG_W + 16;
    localparam int X_W        = PROD_W + 1;

    // Sequencer step counter
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] FILL_LAST  = 4'd7;
    localparam logic [STEP_W-1:0] EV_RD_LAST = 4'd4;
    localparam logic [STEP_W-1:0] EV_SH_LAST = 4'd5;
    localparam logic [STEP_W-1:0] EV_SUM     = 4'd6;
    localparam logic [STEP_W-1:0] EV_ABS     = 4'd7;
    localparam logic [STEP_W-1:0] EV_FEED2   = 4'd9;
    localparam logic [STEP_W-1:0] EV_HOLD1   = 4'd12;
    localparam logic [STEP_W-1:0] EV_LAST    = 4'd13;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACTIVE_POINTS  = 3'd0,
        CFG_BOUNDARY_MODE  = 3'd1,
        CFG_GHOST_OFFSET   = 3'd2,
        CFG_STENCIL_ORDER  = 3'd3,
        CFG_INV_SPACING    = 3'd4,
        CFG_INV_SPACING_SQ = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_FILL  = 2'd1,
        KIND_EVAL  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        BND_SYMMETRIC = 2'd0,
        BND_PERIODIC  = 2'd1,
        BND_ZERO      = 2'd2
    } bnd_mode_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_EDGE  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_EVAL,
        ST_DONE
    } fsm_state_t;

    // controller -> datapath
    typedef struct packed {
        logic       accept;
        logic       clr_we;
        logic       wr_sample;
        logic       fill_rd;
        logic       fill_wr;
        logic [1:0] fill_sel;
        logic       eval_rd;
        logic [2:0] eval_sel;
        logic       tap_shift;
        logic       sum_load;
        logic       abs_load;
        logic       feed_d2;
        logic       hold_d1;
        logic       hold_d2;
        logic       out_load;
    } ctl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       clear_last;
        logic [1:0] kind;
        logic       eval_ok;
        logic       out_free;
    } dp_sts_t;

endpackage

`default_nettype wire

/* sv/fdsg_scale.sv */
// ============================================================================
// fdsg_scale - four-stage scale, round and saturate pipeline
// result = round(floor(mag * h / 65536) / div), div = 1 or 12, ties away
// from zero, sign applied after rounding, clipped to signed 32 bits.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fdsg_scale
    import fdsg_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic [MAG_W-1:0]           mag,
    input  wire logic                       neg,
    input  wire logic [31:0]                h,
    input  wire logic                       div1,
    output logic signed [SAMPLE_W-1:0]      result,
    output logic                            sat
);

    localparam int          Y_W        = 34;
    localparam logic [17:0] DIV3_MAGIC = 18'd174763;   // (2^19 + 1) / 3
    localparam logic [32:0] LIM_POS    = 33'h0_7FFF_FFFF;
    localparam logic [32:0] LIM_NEG    = 33'h0_8000_0000;

    // exact floor(v / 3) for v < 2^19
    function automatic logic [16:0] div3(input logic [17:0] v);
        logic [35:0] p;
        p = 36'(v) * 36'(DIV3_MAGIC);
        return p[35:19];
    endfunction

    // stage 1: split 16-bit partial products
    logic [PROD_W-1:0] lo_reg, hi_reg;
    logic              neg1_reg, div1_1_reg;
    // stage 2: truncated product plus rounding bias
    logic [X_W-1:0]    x_reg;
    logic              neg2_reg, div1_2_reg;
    // stage 3: high digit of divide by 12
    logic [X_W-1:0]    x3_reg;
    logic [16:0]       qh_reg;
    logic [1:0]        rh_reg;
    logic [15:0]       yl_reg;
    logic              ovf_reg, neg3_reg, div1_3_reg;
    // stage 4: final value
    logic signed [SAMPLE_W-1:0] result_reg;
    logic                       sat_reg;

    logic [X_W-1:0]  t_sum;
    logic [X_W-1:0]  y;
    logic [17:0]     yh;
    logic [16:0]     qh;
    logic [17:0]     rh_full;
    logic [17:0]     nxt;
    logic [16:0]     ql;
    logic [32:0]     q;
    logic [32:0]     lim;
    logic            big;
    logic [32:0]     mag_out;
    logic [32:0]     signed_out;

    always_comb
    begin
        t_sum   = X_W'(hi_reg) + X_W'(lo_reg >> 16) + (div1_1_reg ? X_W'(0) : X_W'(6));

        y       = x_reg >> 2;
        yh      = y[Y_W-1:16];
        qh      = div3(yh);
        rh_full = yh - (18'(qh) * 18'd3);

        nxt     = {rh_reg, yl_reg};
        ql      = div3(nxt);
        q       = {qh_reg, 16'b0} + {17'b0, ql[15:0]};
        lim     = neg3_reg ? LIM_NEG : LIM_POS;
        big     = div1_3_reg ? (x3_reg > X_W'(lim)) : (ovf_reg || (q > lim));
        mag_out = big ? lim : (div1_3_reg ? x3_reg[32:0] : q);
        signed_out = neg3_reg ? (33'd0 - mag_out) : mag_out;
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= PROD_W'(mag) * PROD_W'(h[15:0]);
        hi_reg     <= PROD_W'(mag) * PROD_W'(h[31:16]);
        neg1_reg   <= neg;
        div1_1_reg <= div1;

        x_reg      <= t_sum;
        neg2_reg   <= neg1_reg;
        div1_2_reg <= div1_1_reg;

        x3_reg     <= x_reg;
        qh_reg     <= qh;
        rh_reg     <= rh_full[1:0];
        yl_reg     <= y[15:0];
        ovf_reg    <= |y[X_W-1:Y_W];
        neg3_reg   <= neg2_reg;
        div1_3_reg <= div1_2_reg;

        result_reg <= signed_out[SAMPLE_W-1:0];
        sat_reg    <= big;
    end

    assign result = result_reg;
    assign sat    = sat_reg;

endmodule

`default_nettype wire

/* sv/fdsg_datapath.sv */
// ============================================================================
// fdsg_datapath - field store, config registers, stencil and result datapath
// Holds the 1R1W field memory, the five-tap window, the stencil sums, the
// scale pipeline and the output register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fdsg_datapath
    import fdsg_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire ctl_cmd_t                   cmd,
    output dp_sts_t                         sts,
    input  wire logic [1:0]                 kind,
    input  wire logic [9:0]                 point_index,
    input  wire logic signed [SAMPLE_W-1:0] sample_value,
    input  wire logic                       cfg_write,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [31:0]                cfg_data,
    input  wire logic                       result_stall,
    output logic                            result_valid,
    output logic [1:0]                      status,
    output logic signed [SAMPLE_W-1:0]      first_derivative,
    output logic signed [SAMPLE_W-1:0]      second_derivative,
    output logic                            saturated
);

    // configuration
    logic [10:0] active_points_reg;
    logic [1:0]  boundary_mode_reg;
    logic        ghost_offset_reg;
    logic        stencil_order_reg;
    logic [31:0] inv_spacing_reg;
    logic [31:0] inv_spacing_sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_points_reg  <= 11'd1024;
            boundary_mode_reg  <= BND_SYMMETRIC;
            ghost_offset_reg   <= 1'b0;
            stencil_order_reg  <= 1'b0;
            inv_spacing_reg    <= 32'd65536;
            inv_spacing_sq_reg <= 32'd65536;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ACTIVE_POINTS:  active_points_reg  <= cfg_data[10:0];
                CFG_BOUNDARY_MODE:  boundary_mode_reg  <= cfg_data[1:0];
                CFG_GHOST_OFFSET:   ghost_offset_reg   <= cfg_data[0];
                CFG_STENCIL_ORDER:  stencil_order_reg  <= cfg_data[0];
                CFG_INV_SPACING:    inv_spacing_reg    <= cfg_data;
                CFG_INV_SPACING_SQ: inv_spacing_sq_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // latched item
    logic [1:0]                 kind_reg;
    logic [9:0]                 idx_reg;
    logic signed [SAMPLE_W-1:0] sample_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg   <= kind;
            idx_reg    <= point_index;
            sample_reg <= sample_value;
        end
    end

    // point count and index checks
    logic [N_W-1:0] ap_ext, n_pts, imax, idx_ext, k_ext;
    logic           range_bad, edge_bad, eval_ok;

    always_comb
    begin
        ap_ext    = N_W'(active_points_reg);
        if (ap_ext > N_W'(MAX_POINTS))
            n_pts = N_W'(MAX_POINTS);
        else if (ap_ext < N_W'(MIN_POINTS))
            n_pts = N_W'(MIN_POINTS);
        else
            n_pts = ap_ext;
        imax      = n_pts - N_W'(1);
        idx_ext   = N_W'(idx_reg);
        k_ext     = N_W'(ghost_offset_reg);
        range_bad = idx_ext >= n_pts;
        edge_bad  = (idx_ext < N_W'(2)) || ((idx_ext + N_W'(2)) > imax);
        eval_ok   = (kind_reg == KIND_EVAL) && !range_bad && !edge_bad;
    end

    // ghost fill addresses
    logic [N_W-1:0] lo_a, lo_b, hi_a, hi_b, fill_src, fill_dst;

    always_comb
    begin
        lo_a = N_W'(3) + k_ext;
        lo_b = N_W'(2) + k_ext;
        hi_a = imax - N_W'(3) - k_ext;
        hi_b = imax - N_W'(2) - k_ext;
        case (cmd.fill_sel)
            2'd0:    fill_dst = N_W'(0);
            2'd1:    fill_dst = N_W'(1);
            2'd2:    fill_dst = imax;
            default: fill_dst = imax - N_W'(1);
        endcase
        if (boundary_mode_reg == BND_PERIODIC)
        begin
            case (cmd.fill_sel)
                2'd0:    fill_src = hi_a;
                2'd1:    fill_src = hi_b;
                2'd2:    fill_src = lo_a;
                default: fill_src = lo_b;
            endcase
        end
        else
        begin
            case (cmd.fill_sel)
                2'd0:    fill_src = lo_a;
                2'd1:    fill_src = lo_b;
                2'd2:    fill_src = hi_a;
                default: fill_src = hi_b;
            endcase
        end
    end

    // field store, cleared by a sweep after reset
    logic [SAMPLE_W-1:0] field_mem [MAX_POINTS];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]   clr_cnt_reg;
    logic                mem_we, mem_re, fill_we;
    logic [ADDR_W-1:0]   mem_waddr, mem_raddr, eval_addr;
    logic [SAMPLE_W-1:0] mem_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_cnt_reg <= '0;
        else if (cmd.clr_we)
            clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
    end

    always_comb
    begin
        fill_we   = (boundary_mode_reg == BND_SYMMETRIC) ||
                    (boundary_mode_reg == BND_PERIODIC)  ||
                    (boundary_mode_reg == BND_ZERO);
        eval_addr = ADDR_W'(idx_reg) + ADDR_W'(cmd.eval_sel) - ADDR_W'(2);
        mem_we    = 1'b0;
        mem_waddr = clr_cnt_reg;
        mem_wdata = '0;
        if (cmd.clr_we)
        begin
            mem_we = 1'b1;
        end
        else if (cmd.wr_sample)
        begin
            mem_we    = !range_bad;
            mem_waddr = ADDR_W'(idx_reg);
            mem_wdata = sample_reg;
        end
        else if (cmd.fill_wr)
        begin
            mem_we    = fill_we;
            mem_waddr = ADDR_W'(fill_dst);
            mem_wdata = (boundary_mode_reg == BND_ZERO) ? '0 : rd_data_reg;
        end
        mem_re    = cmd.fill_rd || cmd.eval_rd;
        mem_raddr = cmd.fill_rd ? ADDR_W'(fill_src) : eval_addr;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            field_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= field_mem[mem_raddr];
    end

    // five-point window, oldest read (i-2) ends in tap 0
    logic [SAMPLE_W-1:0] tap_reg [5];

    always_ff @(posedge clk)
    begin
        if (cmd.tap_shift)
        begin
            for (int j = 0; j < 4; j++)
                tap_reg[j] <= tap_reg[j+1];
            tap_reg[4] <= rd_data_reg;
        end
    end

    // stencil sums
    logic signed [SUM_W-1:0] e0, e1, e2, e3, e4;
    logic signed [SUM_W-1:0] s1, s2_fourth, s2_second;
    logic signed [SUM_W-1:0] sum1_reg, sum2_reg;
    logic signed [SUM_W-1:0] abs1, abs2;
    logic [MAG_W-1:0]        mag1_reg, mag2_reg;
    logic                    neg1_reg, neg2_reg;

    always_comb
    begin
        e0 = {{(SUM_W-SAMPLE_W){tap_reg[0][SAMPLE_W-1]}}, tap_reg[0]};
        e1 = {{(SUM_W-SAMPLE_W){tap_reg[1][SAMPLE_W-1]}}, tap_reg[1]};
        e2 = {{(SUM_W-SAMPLE_W){tap_reg[2][SAMPLE_W-1]}}, tap_reg[2]};
        e3 = {{(SUM_W-SAMPLE_W){tap_reg[3][SAMPLE_W-1]}}, tap_reg[3]};
        e4 = {{(SUM_W-SAMPLE_W){tap_reg[4][SAMPLE_W-1]}}, tap_reg[4]};
        s1        = (e0 - e4) + ((e3 - e1) <<< 3);
        // 30*f0 = 32*f0 - 2*f0
        s2_fourth = ((e1 + e3) <<< 4) - (e0 + e4) - ((e2 <<< 5) - (e2 <<< 1));
        s2_second = (e1 + e3) - (e2 <<< 1);
        abs1 = sum1_reg[SUM_W-1] ? -sum1_reg : sum1_reg;
        abs2 = sum2_reg[SUM_W-1] ? -sum2_reg : sum2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum_load)
        begin
            sum1_reg <= s1;
            sum2_reg <= stencil_order_reg ? s2_second : s2_fourth;
        end
        if (cmd.abs_load)
        begin
            mag1_reg <= abs1[MAG_W-1:0];
            mag2_reg <= abs2[MAG_W-1:0];
            neg1_reg <= sum1_reg[SUM_W-1];
            neg2_reg <= sum2_reg[SUM_W-1];
        end
    end

    // shared scale pipeline: d1 then d2 on consecutive cycles
    logic signed [SAMPLE_W-1:0] scale_result;
    logic                       scale_sat;

    fdsg_scale u_scale (
        .clk    (clk),
        .mag    (cmd.feed_d2 ? mag2_reg : mag1_reg),
        .neg    (cmd.feed_d2 ? neg2_reg : neg1_reg),
        .h      (cmd.feed_d2 ? inv_spacing_sq_reg : inv_spacing_reg),
        .div1   (cmd.feed_d2 && stencil_order_reg),
        .result (scale_result),
        .sat    (scale_sat)
    );

    logic signed [SAMPLE_W-1:0] d1_hold_reg, d2_hold_reg;
    logic                       sat1_hold_reg, sat2_hold_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.hold_d1)
        begin
            d1_hold_reg   <= scale_result;
            sat1_hold_reg <= scale_sat;
        end
        if (cmd.hold_d2)
        begin
            d2_hold_reg   <= scale_result;
            sat2_hold_reg <= scale_sat;
        end
    end

    // output register
    logic                       result_valid_reg, result_valid_next;
    status_t                    status_reg, status_next;
    logic signed [SAMPLE_W-1:0] d1_out_reg, d2_out_reg;
    logic                       sat_out_reg;

    always_comb
    begin
        case (kind_reg)
            KIND_WRITE: status_next = range_bad ? STATUS_RANGE : STATUS_OK;
            KIND_EVAL:
            begin
                if (range_bad)
                    status_next = STATUS_RANGE;
                else if (edge_bad)
                    status_next = STATUS_EDGE;
                else
                    status_next = STATUS_OK;
            end
            default:    status_next = STATUS_OK;
        endcase
        if (cmd.out_load)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status_reg  <= status_next;
            d1_out_reg  <= eval_ok ? d1_hold_reg : '0;
            d2_out_reg  <= eval_ok ? d2_hold_reg : '0;
            sat_out_reg <= eval_ok && (sat1_hold_reg || sat2_hold_reg);
        end
    end

    assign result_valid      = result_valid_reg;
    assign status            = status_reg;
    assign first_derivative  = d1_out_reg;
    assign second_derivative = d2_out_reg;
    assign saturated         = sat_out_reg;

    assign sts.clear_last = (clr_cnt_reg == ADDR_W'(MAX_POINTS - 1));
    assign sts.kind       = kind_reg;
    assign sts.eval_ok    = eval_ok;
    assign sts.out_free   = !result_valid_reg || !result_stall;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!result_valid_reg || !result_stall))
        else $error("output register loaded over a waiting result");

    a_write_excl: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_we |-> !(cmd.wr_sample || cmd.fill_wr))
        else $error("store write during clear sweep");

    a_sat_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && sat_out_reg) |-> (status_reg == STATUS_OK))
        else $error("saturation flagged on a rejected item");
`endif

endmodule

`default_nettype wire

/* sv/fdsg_ctrl.sv */
// ============================================================================
// fdsg_ctrl - sequencing FSM for the stencil/ghost-fill core
// Runs the clear sweep, accepts items, and steps the datapath through
// sample write, four ghost copies or the five-read evaluate sequence.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module fdsg_ctrl
    import fdsg_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_stall,
    input  wire dp_sts_t sts,
    output ctl_cmd_t     cmd
);

    fsm_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (item_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                case (sts.kind)
                    KIND_FILL: state_next = ST_FILL;
                    KIND_EVAL: state_next = sts.eval_ok ? ST_EVAL : ST_DONE;
                    default:   state_next = ST_DONE;
                endcase
            end
            ST_FILL:
            begin
                if (step_reg == FILL_LAST)
                    state_next = ST_DONE;
                else
                    step_next = step_reg + STEP_W'(1);
            end
            ST_EVAL:
            begin
                if (step_reg == EV_LAST)
                    state_next = ST_DONE;
                else
                    step_next = step_reg + STEP_W'(1);
            end
            ST_DONE:
            begin
                if (sts.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd        = '0;
        item_stall = (state_reg != ST_IDLE);
        case (state_reg)
            ST_CLEAR: cmd.clr_we = 1'b1;
            ST_IDLE:  cmd.accept = item_valid;
            ST_EXEC:  cmd.wr_sample = (sts.kind == KIND_WRITE);
            ST_FILL:
            begin
                // even step reads a source, odd step writes its ghost
                cmd.fill_rd  = !step_reg[0];
                cmd.fill_wr  = step_reg[0];
                cmd.fill_sel = step_reg[2:1];
            end
            ST_EVAL:
            begin
                cmd.eval_rd   = (step_reg <= EV_RD_LAST);
                cmd.eval_sel  = step_reg[2:0];
                cmd.tap_shift = (step_reg != '0) && (step_reg <= EV_SH_LAST);
                cmd.sum_load  = (step_reg == EV_SUM);
                cmd.abs_load  = (step_reg == EV_ABS);
                cmd.feed_d2   = (step_reg == EV_FEED2);
                cmd.hold_d1   = (step_reg == EV_HOLD1);
                cmd.hold_d2   = (step_reg == EV_LAST);
            end
            ST_DONE:  cmd.out_load = sts.out_free;
            default:  ;
        endcase
    end

`ifndef SYNTHESIS
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL) |-> (step_reg <= EV_LAST))
        else $error("evaluate step counter ran past last step");

    a_load_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (state_reg == ST_IDLE))
        else $error("result load did not return sequencer to idle");
`endif

endmodule

`default_nettype wire

/* sv/finite_difference_stencil_ghost_fill_core.sv */
// ============================================================================
// finite_difference_stencil_ghost_fill_core - five-point stencil over a field
// Item channel (item_valid/item_stall): kind, point_index, sample_value. A
// word is taken on a rising edge with valid high and stall low. Kind 0 writes
// one sample, kind 1 fills the two ghost points at each end, kind 2 returns
// d1 and d2 at a point. Every item returns exactly one result word on the
// result channel (result_valid/result_stall).
// Ghost fill makes four read-then-write copies through the store; evaluate
// makes five store reads, passes the sum and abs stages, then sends d1 and
// d2 through the shared 4-stage scale pipeline. The result word goes valid
// at the edge that returns the block to idle.
// Reset: config takes its default values and the store is zeroed by a sweep
// over all MAX_POINTS (1024) addresses, item_stall held high meanwhile.
// A stalled result sits in the output register; the next item is still
// accepted and runs, then waits before loading its result until the old word
// has been taken. Config writes (cfg_write) must go in only while the block
// idles: the user is bound to this, the block itself does not enforce it.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module finite_difference_stencil_ghost_fill_core
    import fdsg_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // item channel
    input  wire logic                       item_valid,
    output logic                            item_stall,
    input  wire logic [1:0]                 kind,
    input  wire logic [9:0]                 point_index,
    input  wire logic signed [SAMPLE_W-1:0] sample_value,
    // result channel
    output logic                            result_valid,
    input  wire logic                       result_stall,
    output logic [1:0]                      status,
    output logic signed [SAMPLE_W-1:0]      first_derivative,
    output logic signed [SAMPLE_W-1:0]      second_derivative,
    output logic                            saturated,
    // configuration write port
    input  wire logic                       cfg_write,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [31:0]                cfg_data
);

    // command and status bundles between sequencer and datapath
    ctl_cmd_t cmd;
    dp_sts_t  sts;

    fdsg_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    fdsg_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .kind              (kind),
        .point_index       (point_index),
        .sample_value      (sample_value),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .result_stall      (result_stall),
        .result_valid      (result_valid),
        .status            (status),
        .first_derivative  (first_derivative),
        .second_derivative (second_derivative),
        .saturated         (saturated)
    );

endmodule

`default_nettype wire

/* verif/tb_finite_difference_stencil_ghost_fill_core.sv */
// ============================================================================
// tb_finite_difference_stencil_ghost_fill_core - self-checking bench
// Drives write, ghost-fill, evaluate and unused-kind words into the stencil
// core, mirrors the field store and registers in a local predictor, and
// checks every result word field by field against the predicted queue.
// Directed cases first (bounds, boundary modes, saturation), then random
// traffic under changing register sets and sender/receiver idling profiles.
// ============================================================================
`timescale 1ns / 1ps

module tb_finite_difference_stencil_ghost_fill_core
    import fdsg_pkg::*;
();

    // ------------------------------------------------------------------------
    // Bench constants
    // ------------------------------------------------------------------------
    localparam int         CLK_HALF      = 6;          // 12 ns period
    localparam int         RESET_CYCLES  = 5;
    localparam int         SETTLE_CYCLES = 24;         // longer than an evaluate occupancy
    localparam int         DRAIN_LIMIT   = 50000;
    localparam int         RANDOM_CHUNK  = 117;        // 6 chunks, ~700 words
    localparam longint     TIMEOUT_NS    = 4_000_000;
    localparam int         REPORT_MAX    = 10;
    localparam logic [1:0] KIND_UNUSED   = 2'd3;       // not in kind_t: block ignores
    localparam logic [1:0] BND_NONE      = 2'd3;       // fill leaves store untouched

    // One predicted result word
    typedef struct packed {
        status_t     status;
        logic [31:0] d1;
        logic [31:0] d2;
        logic        sat;
    } stencil_result_t;

    // ------------------------------------------------------------------------
    // DUT-facing signals; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       item_valid   = 1'b0;
    logic                       item_stall;
    logic [1:0]                 kind         = 2'd0;
    logic [9:0]                 point_index  = 10'd0;
    logic signed [SAMPLE_W-1:0] sample_value = '0;
    logic                       result_valid;
    logic                       result_stall = 1'b0;
    logic [1:0]                 status;
    logic signed [SAMPLE_W-1:0] first_derivative;
    logic signed [SAMPLE_W-1:0] second_derivative;
    logic                       saturated;
    logic                       cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index    = '0;
    logic [31:0]                cfg_data     = '0;

    // ------------------------------------------------------------------------
    // Predictor state: shadow field store and shadow registers
    // ------------------------------------------------------------------------
    logic [31:0] field_shadow [MAX_POINTS];
    logic [10:0] shadow_points;
    logic [1:0]  shadow_boundary;
    logic        shadow_offset;
    logic        shadow_order;
    logic [31:0] shadow_inv_h;
    logic [31:0] shadow_inv_h_sq;

    stencil_result_t pending_results[$];   // in-order expectations
    stencil_result_t oldest;

    // Idling knobs, percent of cycles
    int send_idle_pct = 34;
    int recv_idle_pct = 75;

    // Run statistics
    int mismatches      = 0;
    int words_sent      = 0;
    int words_checked   = 0;
    int in_field_evals  = 0;
    int predicted_clips = 0;
    int config_sets     = 0;

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // DUT
    // ------------------------------------------------------------------------
    finite_difference_stencil_ghost_fill_core u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item_stall        (item_stall),
        .kind              (kind),
        .point_index       (point_index),
        .sample_value      (sample_value),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .status            (status),
        .first_derivative  (first_derivative),
        .second_derivative (second_derivative),
        .saturated         (saturated),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Grid size actually in use: register clamped to [5, MAX_POINTS]
    function automatic int points_in_use();
        int n;
        n = int'(shadow_points);
        if (n > MAX_POINTS)
            n = MAX_POINTS;
        if (n < MIN_POINTS)
            n = MIN_POINTS;
        return n;
    endfunction

    function automatic longint sample_at(int i);
        return longint'($signed(field_shadow[i]));
    endfunction

    // round(floor(s * h / 2^16) / div) half away from zero, clipped to int32.
    // h is split in halves so the product stays inside 64 bits.
    function automatic logic [31:0] scale_q16(input longint s, input logic [31:0] h,
                                              input logic [63:0] div, output bit clipped);
        logic [63:0] mag;
        logic [63:0] t;
        logic [63:0] q;
        bit          neg;
        neg     = (s < 0);
        mag     = neg ? 64'(-s) : 64'(s);
        t       = mag * h[31:16] + ((mag * h[15:0]) >> 16);
        q       = (t + div / 2) / div;
        clipped = 1'b0;
        if (!neg)
        begin
            if (q > 64'h7FFF_FFFF)
            begin
                clipped = 1'b1;
                q       = 64'h7FFF_FFFF;
            end
        end
        else
        begin
            if (q > 64'h8000_0000)
            begin
                clipped = 1'b1;
                q       = 64'h8000_0000;
            end
            q = -q;
        end
        return q[31:0];
    endfunction

    // Four sequential copies; later copies see earlier ones (matters on tiny grids)
    function automatic void fill_ghosts();
        int g;
        int top;
        g   = int'(shadow_offset);
        top = points_in_use() - 1;
        case (shadow_boundary)
            BND_SYMMETRIC:
            begin
                field_shadow[0]       = field_shadow[3 + g];
                field_shadow[1]       = field_shadow[2 + g];
                field_shadow[top]     = field_shadow[top - 3 - g];
                field_shadow[top - 1] = field_shadow[top - 2 - g];
            end
            BND_PERIODIC:
            begin
                field_shadow[0]       = field_shadow[top - 3 - g];
                field_shadow[1]       = field_shadow[top - 2 - g];
                field_shadow[top]     = field_shadow[3 + g];
                field_shadow[top - 1] = field_shadow[2 + g];
            end
            BND_ZERO:
            begin
                field_shadow[0]       = '0;
                field_shadow[1]       = '0;
                field_shadow[top]     = '0;
                field_shadow[top - 1] = '0;
            end
            default:
                ;
        endcase
    endfunction

    // Apply one accepted word to the shadow state and return its result word
    function automatic stencil_result_t apply_word(logic [1:0] k, logic [9:0] idx,
                                                   logic [31:0] val);
        stencil_result_t r;
        int              n;
        int              i;
        longint          fm2, fm1, f0, fp1, fp2;
        longint          s1, s2;
        bit              c1, c2;
        r        = '0;
        r.status = STATUS_OK;
        n        = points_in_use();
        i        = int'(idx);
        c2       = 1'b0;
        case (k)
            KIND_WRITE:
            begin
                if (i >= n)
                    r.status = STATUS_RANGE;
                else
                    field_shadow[i] = val;
            end
            KIND_FILL:
                fill_ghosts();
            KIND_EVAL:
            begin
                if (i >= n)
                    r.status = STATUS_RANGE;
                else if (i < 2 || i + 2 > n - 1)
                    r.status = STATUS_EDGE;
                else
                begin
                    fm2  = sample_at(i - 2);
                    fm1  = sample_at(i - 1);
                    f0   = sample_at(i);
                    fp1  = sample_at(i + 1);
                    fp2  = sample_at(i + 2);
                    s1   = fm2 - 8 * fm1 + 8 * fp1 - fp2;
                    r.d1 = scale_q16(s1, shadow_inv_h, 64'd12, c1);
                    if (shadow_order == 1'b0)
                    begin
                        s2   = -fm2 + 16 * fm1 - 30 * f0 + 16 * fp1 - fp2;
                        r.d2 = scale_q16(s2, shadow_inv_h_sq, 64'd12, c2);
                    end
                    else
                    begin
                        s2   = fm1 - 2 * f0 + fp1;
                        r.d2 = scale_q16(s2, shadow_inv_h_sq, 64'd1, c2);
                    end
                    r.sat = c1 | c2;
                    in_field_evals++;
                    if (r.sat)
                        predicted_clips++;
                end
            end
            default:
                ;   // unused kind: no effect, zero result
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driver tasks. All of them run aligned to a rising edge.
    // ------------------------------------------------------------------------

    // Send one word. Valid is left high on exit so a back-to-back word never
    // sees valid dropped and raised in one step; idle cycles drop it here.
    task automatic send_word(logic [1:0] k, logic [9:0] idx, logic [31:0] val);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid   <= 1'b1;
        kind         <= k;
        point_index  <= idx;
        sample_value <= val;
        do
            @(posedge clk);
        while (item_stall);
        pending_results.push_back(apply_word(k, idx, val));
        words_sent++;
    endtask

    // Sender pause: valid low until every expected word is back, then let
    // the block go quiet before any register write.
    task automatic drain_results();
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write; cfg_write is lowered by the caller after the burst
    task automatic write_reg(cfg_reg_t r, logic [31:0] d);
        cfg_write <= 1'b1;
        cfg_index <= r;
        cfg_data  <= d;
        @(posedge clk);
        case (r)
            CFG_ACTIVE_POINTS:  shadow_points   = d[10:0];
            CFG_BOUNDARY_MODE:  shadow_boundary = d[1:0];
            CFG_GHOST_OFFSET:   shadow_offset   = d[0];
            CFG_STENCIL_ORDER:  shadow_order    = d[0];
            CFG_INV_SPACING:    shadow_inv_h    = d;
            CFG_INV_SPACING_SQ: shadow_inv_h_sq = d;
            default:            ;
        endcase
    endtask

    // Full register set; only called with the block idle
    task automatic program_grid(logic [10:0] pts, logic [1:0] bnd, logic off, logic ord,
                                logic [31:0] inv_h, logic [31:0] inv_h_sq);
        write_reg(CFG_ACTIVE_POINTS,  {21'd0, pts});
        write_reg(CFG_BOUNDARY_MODE,  {30'd0, bnd});
        write_reg(CFG_GHOST_OFFSET,   {31'd0, off});
        write_reg(CFG_STENCIL_ORDER,  {31'd0, ord});
        write_reg(CFG_INV_SPACING,    inv_h);
        write_reg(CFG_INV_SPACING_SQ, inv_h_sq);
        cfg_write <= 1'b0;
        config_sets++;
    endtask

    // ------------------------------------------------------------------------
    // Result monitor: checks accepted words, then picks the next stall
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: result word with nothing expected: ", $realtime,
                             "status=%0d d1=%h d2=%h sat=%b",
                             status, first_derivative, second_derivative, saturated);
            end
            else
            begin
                oldest = pending_results.pop_front();
                words_checked++;
                if (status !== oldest.status || first_derivative !== oldest.d1 ||
                    second_derivative !== oldest.d2 || saturated !== oldest.sat)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("%0t: word %0d mismatch: ", $realtime, words_checked,
                                 "exp status=%0d d1=%h d2=%h sat=%b, ",
                                 oldest.status, oldest.d1, oldest.d2, oldest.sat,
                                 "got status=%0d d1=%h d2=%h sat=%b",
                                 status, first_derivative, second_derivative, saturated);
                end
            end
        end
        result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Defaults after reset: 1024 points, cleared store, unit spacing.
    // Hits both ends of the grid, the edge band and the unused kind.
    task automatic test_reset_state();
        send_word(KIND_EVAL,   10'd500,  32'h0);           // cleared store -> zero
        send_word(KIND_WRITE,  10'd1023, 32'h7FFF_FFFF);   // last point, max sample
        send_word(KIND_WRITE,  10'd0,    32'h8000_0000);   // first point, min sample
        send_word(KIND_EVAL,   10'd1021, 32'h0);           // last in-field point
        send_word(KIND_EVAL,   10'd1022, 32'h0);           // edge band, top
        send_word(KIND_EVAL,   10'd1,    32'h0);           // edge band, bottom
        send_word(KIND_UNUSED, 10'h3FF,  32'hFFFF_FFFF);   // ignored, all ones
    endtask

    // Smallest grid (register below 5 clamps to 5) through every boundary
    // mode, both ghost offsets and both stencil orders.
    task automatic test_ghost_fill();
        drain_results();
        program_grid(11'd0, BND_SYMMETRIC, 1'b1, 1'b0, 32'h0001_0000, 32'h0001_0000);
        send_word(KIND_WRITE, 10'd2, 32'h0003_0000);
        send_word(KIND_WRITE, 10'd3, 32'hFFFE_8000);
        send_word(KIND_WRITE, 10'd4, 32'h0010_0000);
        send_word(KIND_WRITE, 10'd7, 32'h1234_5678);       // beyond grid: store untouched
        send_word(KIND_FILL,  10'd0, 32'h0);
        send_word(KIND_EVAL,  10'd2, 32'h0);
        send_word(KIND_EVAL,  10'd5, 32'h0);               // beyond grid

        drain_results();
        program_grid(11'd5, BND_PERIODIC, 1'b0, 1'b1, 32'h0002_0000, 32'h0000_4000);
        send_word(KIND_FILL, 10'd0, 32'h0);
        send_word(KIND_EVAL, 10'd2, 32'h0);

        drain_results();
        program_grid(11'd5, BND_ZERO, 1'b1, 1'b0, 32'h0001_8000, 32'h0003_0000);
        send_word(KIND_FILL, 10'd0, 32'h0);
        send_word(KIND_EVAL, 10'd2, 32'h0);

        // reserved boundary mode: fill is a no-op
        drain_results();
        program_grid(11'd5, BND_NONE, 1'b0, 1'b0, 32'h0001_0000, 32'h0001_0000);
        send_word(KIND_WRITE, 10'd0, 32'h0000_8000);
        send_word(KIND_FILL,  10'd0, 32'h0);
        send_word(KIND_EVAL,  10'd2, 32'h0);
    endtask

    // Extreme neighbors with the largest and smallest spacings; a register
    // above MAX_POINTS clamps down to it.
    task automatic test_saturation();
        drain_results();
        program_grid(11'd2047, BND_SYMMETRIC, 1'b0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(KIND_WRITE, 10'd11, 32'h7FFF_FFFF);
        send_word(KIND_WRITE, 10'd13, 32'h8000_0000);
        send_word(KIND_EVAL,  10'd12, 32'h0);              // d1 clips, d2 stays in range
        drain_results();
        program_grid(11'd1024, BND_SYMMETRIC, 1'b0, 1'b0, 32'h0, 32'hFFFF_FFFF);
        send_word(KIND_EVAL,  10'd12, 32'h0);              // d1 zero, d2 fourth order
    endtask

    // Random register set per chunk: mostly small grids so writes and
    // evaluations land on the same points, now and then the clamped extremes.
    task automatic shuffle_registers();
        logic [10:0] pts;
        logic [31:0] h [2];
        case ($urandom_range(0, 9))
            0:       pts = 11'($urandom_range(0, MIN_POINTS - 1));
            1:       pts = 11'($urandom_range(MAX_POINTS + 1, 2047));
            2:       pts = 11'(MAX_POINTS);
            default: pts = 11'($urandom_range(MIN_POINTS, 48));
        endcase
        foreach (h[j])
        begin
            case ($urandom_range(0, 3))
                0:       h[j] = $urandom;
                1:       h[j] = $urandom_range(0, 32'hFFFF);
                default: h[j] = $urandom_range(32'h8000, 32'h4_0000);
            endcase
        end
        drain_results();
        program_grid(pts, 2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom), h[0], h[1]);
    endtask

    task automatic test_random_traffic(int words);
        int          n;
        int          pick;
        logic [1:0]  k;
        logic [9:0]  idx;
        logic [31:0] val;
        shuffle_registers();
        repeat (words)
        begin
            n    = points_in_use();
            pick = $urandom_range(0, 99);
            if (pick < 45)
                k = KIND_WRITE;
            else if (pick < 85)
                k = KIND_EVAL;
            else if (pick < 95)
                k = KIND_FILL;
            else
                k = KIND_UNUSED;

            // mostly on the grid, some right at the edge band, some anywhere
            pick = $urandom_range(0, 99);
            if (pick < 70)
                idx = 10'($urandom_range(0, n - 1));
            else if (pick < 85)
            begin
                case ($urandom_range(0, 5))
                    0:       idx = 10'd0;
                    1:       idx = 10'd1;
                    2:       idx = 10'd2;
                    3:       idx = 10'(n - 3);
                    4:       idx = 10'(n - 2);
                    default: idx = 10'(n - 1);
                endcase
            end
            else
                idx = 10'($urandom);

            case ($urandom_range(0, 9))
                0:       val = 32'h7FFF_FFFF;
                1:       val = 32'h8000_0000;
                2, 3:    val = $urandom;
                default: val = $urandom_range(0, 32'h1F_FFFF) - 32'h10_0000;  // +/-16.0
            endcase
            send_word(k, idx, val);
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    initial
    begin
        int waited;
        waited = 0;

        // shadow state matches the reset image
        foreach (field_shadow[j])
            field_shadow[j] = '0;
        shadow_points   = 11'd1024;
        shadow_boundary = BND_SYMMETRIC;
        shadow_offset   = 1'b0;
        shadow_order    = 1'b0;
        shadow_inv_h    = 32'h0001_0000;
        shadow_inv_h_sq = 32'h0001_0000;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        // store clear sweep after reset holds item_stall high
        repeat (2) @(posedge clk);
        while (item_stall)
            @(posedge clk);

        // slow sender, very slow receiver
        send_idle_pct = 34;
        recv_idle_pct = 75;
        test_reset_state();
        test_ghost_fill();
        test_saturation();
        repeat (2) test_random_traffic(RANDOM_CHUNK);

        // profiles swapped
        send_idle_pct = 75;
        recv_idle_pct = 34;
        repeat (2) test_random_traffic(RANDOM_CHUNK);

        // full rate both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (2) test_random_traffic(RANDOM_CHUNK);

        item_valid <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (pending_results.size() != 0)
        begin
            $display("%0d expected result words never arrived", pending_results.size());
            mismatches += pending_results.size();
        end

        $display("covered %0d words (%0d checked) over %0d register sets",
                 words_sent, words_checked, config_sets);
        $display("%0d in-field evaluations, %0d of them clipped; %0d mismatches",
                 in_field_evals, predicted_clips, mismatches);
        if (mismatches == 0)
            $display("tb_finite_difference_stencil_ghost_fill_core: done, clean");
        else
            $display("tb_finite_difference_stencil_ghost_fill_core: done, errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #TIMEOUT_NS;
        $display("tb_finite_difference_stencil_ghost_fill_core: done, errors");
        $finish;
    end

endmodule
